[rtl/rms_norm_row_macros.svh]
// assertion macros for the rtl files, included by rms_norm_row.sv
`ifndef RMS_NORM_ROW_MACROS_SVH
`define RMS_NORM_ROW_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on aclk, off during reset
`define RMSN_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RMSN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RMSN_ASSERT_IMPL(lbl, ante, cons, msg)
`define RMSN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/rmsn_pkg.sv]
package rmsn_pkg;

    localparam int MAX_ROW = 64;
    localparam int CFG_W   = 7;
    localparam int CNT_W   = $clog2(MAX_ROW + 1);
    localparam int ADDR_W  = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

    localparam logic [31:0] FP_EPS       = 32'h3727_C5AC;
    localparam logic [31:0] FP_ONE       = 32'h3F80_0000;
    localparam logic [31:0] FP_QNAN_DFLT = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET_BIT = 32'h0040_0000;
    localparam logic [31:0] FP_POS_INF   = 32'h7F80_0000;
    // sums below 2^-50 vanish against the epsilon
    localparam logic [7:0]  FLUSH_EXP    = 8'd77;

    typedef struct packed {
        logic             start;
        logic [31:0]      sum;
        logic [CNT_W-1:0] count;
    } rmsn_scale_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] scale;
    } rmsn_scale_rsp_t;

    // fp32 to bfloat16, round to nearest even, nan kept quiet
    function automatic logic [15:0] fp_to_bf16(input logic [31:0] f);
        logic [31:0] r;
        r = f + 32'h0000_7FFF + {31'b0, f[16]};
        if (f[30:23] == 8'hFF && f[22:0] != 23'b0) begin
            return f[31:16] | 16'h0040;
        end
        return r[31:16];
    endfunction

    // small nonzero unsigned integer to fp32, exact
    function automatic logic [31:0] u7_to_fp(input logic [CFG_W-1:0] n);
        logic [2:0]  k;
        logic [29:0] sh;
        k = 3'd0;
        for (int i = 0; i < CFG_W; i++) begin
            if (n[i]) k = 3'(i);
        end
        sh = 30'(n) << (5'd23 - 5'(k));
        return {1'b0, 8'd127 + 8'(k), sh[22:0]};
    endfunction

    // bf16 x bf16 product as fp32, ieee with subnormals
    function automatic logic [31:0] fp_mul_bf16(input logic [15:0] a, input logic [15:0] b);
        logic               s;
        logic [7:0]         ea, eb, sa, sb;
        logic [15:0]        p, pn;
        logic [4:0]         lz;
        logic signed [10:0] be, sh;
        logic [49:0]        w;
        logic               inc;
        logic [31:0]        r;
        s  = a[15] ^ b[15];
        ea = a[14:7];
        eb = b[14:7];
        sa = {ea != 8'd0, a[6:0]};
        sb = {eb != 8'd0, b[6:0]};
        p  = 16'(sa) * 16'(sb);
        lz = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (p[i]) lz = 5'(15 - i);
        end
        pn = p << lz;
        be = $signed(11'((ea == 8'd0) ? 8'd1 : ea)) + $signed(11'((eb == 8'd0) ? 8'd1 : eb))
             - $signed(11'(lz)) - 11'sd126;
        sh  = 11'sd1 - be;
        w   = {pn, 34'b0} >> sh[4:0];
        inc = w[25] & ((|w[24:0]) | w[26]);
        if (ea == 8'hFF && a[6:0] != 7'd0) begin
            r = {a, 16'b0} | FP_QUIET_BIT;
        end else if (eb == 8'hFF && b[6:0] != 7'd0) begin
            r = {b, 16'b0} | FP_QUIET_BIT;
        end else if ((ea == 8'hFF && b[14:0] == 15'd0) || (eb == 8'hFF && a[14:0] == 15'd0)) begin
            r = FP_QNAN_DFLT;
        end else if (ea == 8'hFF || eb == 8'hFF) begin
            r = {s, FP_POS_INF[30:0]};
        end else if (p == 16'd0) begin
            r = {s, 31'b0};
        end else if (be >= 11'sd255) begin
            r = {s, FP_POS_INF[30:0]};
        end else if (be >= 11'sd1) begin
            r = {s, be[7:0], pn[14:0], 8'b0};
        end else if (sh > 11'sd25) begin
            r = {s, 31'b0};
        end else begin
            r = {s, 8'b0, w[48:26]} + {31'b0, inc};
        end
        return r;
    endfunction

    // sum of two non-negative fp32 values, nan of a first
    function automatic logic [31:0] fp_add_pos(input logic [31:0] a, input logic [31:0] b);
        logic [7:0]  ea, eb, eg, es, d;
        logic [23:0] sg, ss;
        logic [50:0] sm;
        logic [31:0] pk, r;
        logic        g, st, inc;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        if (eb > ea) begin
            eg = eb; es = ea;
            sg = {b[30:23] != 8'd0, b[22:0]};
            ss = {a[30:23] != 8'd0, a[22:0]};
        end else begin
            eg = ea; es = eb;
            sg = {a[30:23] != 8'd0, a[22:0]};
            ss = {b[30:23] != 8'd0, b[22:0]};
        end
        d  = eg - es;
        sm = {1'b0, sg, 26'b0} + ({1'b0, ss, 26'b0} >> d);
        if (sm[50]) begin
            pk = {1'b0, eg + 8'd1, sm[49:27]};
            g  = sm[26];
            st = |sm[25:0];
        end else begin
            pk = {1'b0, sm[49] ? eg : 8'd0, sm[48:26]};
            g  = sm[25];
            st = |sm[24:0];
        end
        inc = g & (st | pk[0]);
        r   = pk + {31'b0, inc};
        if (a[30:23] == 8'hFF && a[22:0] != 23'd0) begin
            return a | FP_QUIET_BIT;
        end else if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
            return b | FP_QUIET_BIT;
        end else if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
            return FP_POS_INF;
        end else if (d >= 8'd27) begin
            return (eb > ea) ? b : a;
        end else if (r[31:23] >= 9'd255) begin
            return FP_POS_INF;
        end
        return r;
    endfunction

endpackage

[rtl/rmsn_row_buf.sv]
module rmsn_row_buf (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [rmsn_pkg::ADDR_W-1:0] wr_addr,
    input  logic [15:0]                wr_data,
    input  logic                       rd_en,
    input  logic [rmsn_pkg::ADDR_W-1:0] rd_addr,
    output logic [15:0]                rd_data
);

    logic [15:0] mem [rmsn_pkg::MAX_ROW];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rmsn_scale.sv]
module rmsn_scale (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rmsn_pkg::rmsn_scale_req_t req,
    output rmsn_pkg::rmsn_scale_rsp_t rsp
);

    typedef enum logic [2:0] {
        SC_IDLE, SC_DIV, SC_DIVFIN, SC_ADD, SC_SQINIT, SC_SQRT, SC_SQFIN
    } sc_state_t;

    sc_state_t          state_reg;
    logic               recip_reg;
    logic [25:0]        rem_reg;
    logic [23:0]        den_reg;
    logic [24:0]        quo_reg;
    logic signed [9:0]  exp_reg;
    logic [4:0]         cnt_reg;
    logic [49:0]        sq_x_reg;
    logic [27:0]        sq_rem_reg;
    logic [24:0]        sq_root_reg;
    logic signed [9:0]  sq_hexp_reg;
    logic [31:0]        val_reg;
    logic [15:0]        scale_reg;
    logic               done_reg;

    // divider setup
    logic [31:0]        div_a, div_b, n_fp, sqrt_bits, q_fp;
    logic [23:0]        ma, mb;
    logic               lt;
    logic [25:0]        rem0;
    logic signed [9:0]  e0;
    logic               q_inc;
    // sqrt steps and finish
    logic [27:0]        rt_rem;
    logic [26:0]        rt_trial;
    logic [23:0]        rt_r;
    logic [24:0]        rt_r25;
    logic               rt_inc;
    logic signed [9:0]  rt_exp;
    logic               sq_odd;
    logic [23:0]        sq_m;

    assign n_fp = rmsn_pkg::u7_to_fp(rmsn_pkg::CFG_W'(req.count));

    always_comb begin
        rt_r      = sq_root_reg[24:1];
        rt_inc    = sq_root_reg[0] & ((sq_rem_reg != 28'd0) | rt_r[0]);
        rt_r25    = {1'b0, rt_r} + {24'b0, rt_inc};
        rt_exp    = sq_hexp_reg + 10'sd127 + $signed({9'b0, rt_r25[24]});
        sqrt_bits = {1'b0, rt_exp[7:0], rt_r25[24] ? 23'b0 : rt_r25[22:0]};
        if (state_reg == SC_SQFIN) begin
            div_a = rmsn_pkg::FP_ONE;
            div_b = sqrt_bits;
        end else begin
            div_a = req.sum;
            div_b = n_fp;
        end
        ma   = {1'b1, div_a[22:0]};
        mb   = {1'b1, div_b[22:0]};
        lt   = ma < mb;
        rem0 = lt ? {1'b0, ma, 1'b0} : {2'b0, ma};
        e0   = $signed({2'b0, div_a[30:23]}) - $signed({2'b0, div_b[30:23]}) + 10'sd127
               - $signed({9'b0, lt});
        q_inc = quo_reg[0] & ((rem_reg != 26'd0) | quo_reg[1]);
        q_fp  = {1'b0, exp_reg[7:0], quo_reg[23:1]} + {31'b0, q_inc};
        rt_rem   = {sq_rem_reg[25:0], sq_x_reg[49:48]};
        rt_trial = {sq_root_reg, 2'b01};
        sq_odd   = ~val_reg[23];
        sq_m     = {1'b1, val_reg[22:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                SC_IDLE: begin
                    if (req.start) begin
                        if (req.sum[30:23] == 8'hFF && req.sum[22:0] != 23'd0) begin
                            scale_reg <= rmsn_pkg::fp_to_bf16(req.sum | rmsn_pkg::FP_QUIET_BIT);
                            done_reg  <= 1'b1;
                        end else if (req.sum[30:23] == 8'hFF) begin
                            scale_reg <= 16'h0000;
                            done_reg  <= 1'b1;
                        end else if (req.sum[30:23] < rmsn_pkg::FLUSH_EXP) begin
                            val_reg   <= rmsn_pkg::FP_EPS;
                            state_reg <= SC_SQINIT;
                        end else begin
                            rem_reg   <= rem0;
                            den_reg   <= mb;
                            exp_reg   <= e0;
                            quo_reg   <= 25'd0;
                            cnt_reg   <= 5'd0;
                            recip_reg <= 1'b0;
                            state_reg <= SC_DIV;
                        end
                    end
                end
                SC_DIV: begin
                    if (rem_reg >= {2'b0, den_reg}) begin
                        quo_reg <= {quo_reg[23:0], 1'b1};
                        rem_reg <= {rem_reg[24:0] - {1'b0, den_reg}, 1'b0};
                    end else begin
                        quo_reg <= {quo_reg[23:0], 1'b0};
                        rem_reg <= {rem_reg[24:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd24) begin
                        state_reg <= SC_DIVFIN;
                    end
                end
                SC_DIVFIN: begin
                    if (recip_reg) begin
                        scale_reg <= rmsn_pkg::fp_to_bf16(q_fp);
                        done_reg  <= 1'b1;
                        state_reg <= SC_IDLE;
                    end else begin
                        val_reg   <= q_fp;
                        state_reg <= SC_ADD;
                    end
                end
                SC_ADD: begin
                    val_reg   <= rmsn_pkg::fp_add_pos(val_reg, rmsn_pkg::FP_EPS);
                    state_reg <= SC_SQINIT;
                end
                SC_SQINIT: begin
                    sq_x_reg    <= sq_odd ? {sq_m, 26'b0} : {1'b0, sq_m, 25'b0};
                    sq_hexp_reg <= ($signed({2'b0, val_reg[30:23]}) - 10'sd127
                                    - $signed({9'b0, sq_odd})) >>> 1;
                    sq_rem_reg  <= 28'd0;
                    sq_root_reg <= 25'd0;
                    cnt_reg     <= 5'd0;
                    state_reg   <= SC_SQRT;
                end
                SC_SQRT: begin
                    if (rt_rem >= {1'b0, rt_trial}) begin
                        sq_rem_reg  <= rt_rem - {1'b0, rt_trial};
                        sq_root_reg <= {sq_root_reg[23:0], 1'b1};
                    end else begin
                        sq_rem_reg  <= rt_rem;
                        sq_root_reg <= {sq_root_reg[23:0], 1'b0};
                    end
                    sq_x_reg <= {sq_x_reg[47:0], 2'b00};
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd24) begin
                        state_reg <= SC_SQFIN;
                    end
                end
                SC_SQFIN: begin
                    rem_reg   <= rem0;
                    den_reg   <= mb;
                    exp_reg   <= e0;
                    quo_reg   <= 25'd0;
                    cnt_reg   <= 5'd0;
                    recip_reg <= 1'b1;
                    state_reg <= SC_DIV;
                end
                default: begin
                    state_reg <= SC_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.scale = scale_reg;

endmodule

[rtl/rms_norm_row.sv]
// channel   | ports                                  | direction
// ----------+----------------------------------------+----------
// input     | s_valid s_ready s_element_value        | in
// result    | m_valid m_ready m_normalized_value     | out
//           |   m_last_of_row                        |
// config    | cfg_valid cfg_ready cfg_row_length     | in
//
// load phase: one element per cycle, written to the row memory
// after the completing element: the square/sum pipe drains, then the scale
//   sequencer (a 25-step divide, a 25-step root, a 25-step reciprocal divide)
// emit phase: per result, one memory read plus one product
// the output register decouples m_ready stalls from the next row's load
// synchronous active-low reset; row memory contents are not cleared
`include "rms_norm_row_macros.svh"

module rms_norm_row (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [15:0]                 s_element_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_normalized_value,
    output logic                        m_last_of_row,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rmsn_pkg::CFG_W-1:0]  cfg_row_length
);

    typedef enum logic [2:0] {
        ST_FILL, ST_DRAIN, ST_SCALE, ST_WAIT, ST_RD, ST_LD
    } state_t;

    localparam int CNT_W = rmsn_pkg::CNT_W;

    state_t                       state_reg;
    logic [rmsn_pkg::CFG_W-1:0]   row_length_reg;
    logic [CNT_W-1:0]             fill_count_reg;
    logic [CNT_W-1:0]             n_reg;
    logic [CNT_W-1:0]             rd_idx_reg;
    logic [31:0]                  sum_reg;
    logic [15:0]                  x_reg;
    logic                         xv_reg;
    logic [31:0]                  sq_reg;
    logic                         sqv_reg;
    logic [15:0]                  scale_reg;
    logic                         m_valid_reg;
    logic [15:0]                  m_value_reg;
    logic                         m_last_reg;

    logic                         s_xfer;
    logic [CNT_W-1:0]             len_eff;
    logic [CNT_W-1:0]             fill_inc;
    logic                         rd_en;
    logic [15:0]                  rd_data;
    logic                         last_rd;
    rmsn_pkg::rmsn_scale_req_t    scale_req;
    rmsn_pkg::rmsn_scale_rsp_t    scale_rsp;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_FILL);
    assign s_xfer    = s_valid & s_ready;
    assign fill_inc  = fill_count_reg + CNT_W'(1);

    // clamp the configured length to 1..MAX_ROW
    always_comb begin
        if (row_length_reg == '0) begin
            len_eff = CNT_W'(1);
        end else if (row_length_reg > rmsn_pkg::CFG_W'(rmsn_pkg::MAX_ROW)) begin
            len_eff = CNT_W'(rmsn_pkg::MAX_ROW);
        end else begin
            len_eff = CNT_W'(row_length_reg);
        end
    end

    // read only once the output register is free or being drained
    assign rd_en   = (state_reg == ST_RD) && (!m_valid_reg || m_ready);
    assign last_rd = (CNT_W'(rd_idx_reg + CNT_W'(1)) == n_reg);

    rmsn_row_buf u_row_buf (
        .aclk    (aclk),
        .wr_en   (s_xfer),
        .wr_addr (fill_count_reg[rmsn_pkg::ADDR_W-1:0]),
        .wr_data (s_element_value),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[rmsn_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign scale_req.start = (state_reg == ST_SCALE);
    assign scale_req.sum   = sum_reg;
    assign scale_req.count = n_reg;

    rmsn_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (scale_req),
        .rsp     (scale_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            row_length_reg <= rmsn_pkg::CFG_W'(64);
            fill_count_reg <= '0;
            sum_reg        <= 32'h0000_0000;
            xv_reg         <= 1'b0;
            sqv_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                row_length_reg <= cfg_row_length;
            end

            // square and accumulate pipe, in arrival order
            xv_reg  <= s_xfer;
            sqv_reg <= xv_reg;
            if (s_xfer) begin
                x_reg <= s_element_value;
            end
            if (xv_reg) begin
                sq_reg <= rmsn_pkg::fp_mul_bf16(x_reg, x_reg);
            end
            if (state_reg == ST_SCALE) begin
                sum_reg <= 32'h0000_0000;
            end else if (sqv_reg) begin
                sum_reg <= rmsn_pkg::fp_add_pos(sum_reg, sq_reg);
            end

            // output register empties on a result transfer
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_FILL: begin
                    if (s_xfer) begin
                        if (fill_inc >= len_eff) begin
                            n_reg          <= fill_inc;
                            fill_count_reg <= '0;
                            state_reg      <= ST_DRAIN;
                        end else begin
                            fill_count_reg <= fill_inc;
                        end
                    end
                end
                ST_DRAIN: begin
                    // wait for the last square to land in the sum
                    if (!xv_reg && !sqv_reg) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (scale_rsp.done) begin
                        scale_reg  <= scale_rsp.scale;
                        rd_idx_reg <= '0;
                        state_reg  <= ST_RD;
                    end
                end
                ST_RD: begin
                    if (rd_en) begin
                        state_reg <= ST_LD;
                    end
                end
                ST_LD: begin
                    m_value_reg <= rmsn_pkg::fp_to_bf16(rmsn_pkg::fp_mul_bf16(rd_data, scale_reg));
                    m_last_reg  <= last_rd;
                    m_valid_reg <= 1'b1;
                    rd_idx_reg  <= CNT_W'(rd_idx_reg + CNT_W'(1));
                    state_reg   <= last_rd ? ST_FILL : ST_RD;
                end
                default: begin
                    state_reg <= ST_FILL;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_normalized_value = m_value_reg;
    assign m_last_of_row      = m_last_reg;

    `RMSN_ASSERT_IMPL(a_ld_out_free, state_reg == ST_LD, !m_valid_reg, "output register busy on load")
    `RMSN_ASSERT_IMPL(a_scale_after_sum, state_reg == ST_SCALE, !xv_reg && !sqv_reg, "sum not settled")
    `RMSN_ASSERT_IMPL(a_fill_bound, 1'b1, fill_count_reg < CNT_W'(rmsn_pkg::MAX_ROW), "fill overrun")
    `RMSN_ASSERT_NEXT(a_last_to_fill, state_reg == ST_LD && last_rd, state_reg == ST_FILL, "row end lost")

endmodule

[sim/rms_norm_row_test.sv]
module rms_norm_row_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    // settle time after the last expected result, with margin
    localparam int SETTLE_CYCLES  = 200;
    localparam int TARGET_ITEMS   = 250;
    localparam logic [31:0] EPS_F32 = 32'h3727_C5AC;
    localparam logic [31:0] ONE_F32 = 32'h3F80_0000;
    localparam logic [31:0] QUIET   = 32'h0040_0000;

    typedef struct {
        logic [15:0] value;
        logic        last;
    } norm_result_t;

    // row predictor and store of expected normalized results
    class row_norm_scoreboard;
        logic [15:0]  row_buf[64];
        logic [31:0]  sq_sum;
        int           filled;
        int           length_reg;
        int           mismatches;
        norm_result_t expected_q[$];

        function new();
            sq_sum     = 32'd0;
            filled     = 0;
            length_reg = 64;
            mismatches = 0;
        endfunction

        function bit is_nan(logic [31:0] a);
            return a[30:23] == 8'hFF && a[22:0] != 23'd0;
        endfunction

        function void split(logic [31:0] a, output logic [63:0] sig, output int ex);
            if (a[30:23] == 8'd0) begin
                sig = {41'd0, a[22:0]};
                ex  = -149;
            end else begin
                sig = {40'd0, 1'b1, a[22:0]};
                ex  = int'(a[30:23]) - 150;
            end
        endfunction

        // value sig * 2^ex, rounded to fp32 nearest even, subnormals kept
        function logic [31:0] round_f32(bit s, logic [63:0] sig, int ex, bit sticky_in);
            int          p, e_top, sh;
            logic [63:0] m;
            bit          g, st;
            p = 0;
            for (int i = 0; i < 64; i++) begin
                if (sig[i]) p = i;
            end
            e_top = ex + p;
            sh = (e_top >= -126) ? p - 23 : -149 - ex;
            if (sh <= 0) begin
                m = sig << (-sh);
                g = 1'b0;
                st = sticky_in;
            end else if (sh > 64) begin
                m = 64'd0;
                g = 1'b0;
                st = 1'b1;
            end else begin
                m = sig >> sh;
                g = sig[sh-1];
                st = sticky_in || ((sig & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0);
            end
            if (g && (st || m[0])) m = m + 64'd1;
            if (e_top >= -126) begin
                if (m[24]) begin
                    m = m >> 1;
                    e_top++;
                end
                if (e_top > 127) return {s, 8'hFF, 23'd0};
                return {s, 8'(e_top + 127), m[22:0]};
            end
            return {s, m[30:0]};
        endfunction

        function logic [31:0] mul_f32(logic [31:0] a, logic [31:0] b);
            bit          s, a_inf, b_inf, a_zero, b_zero;
            logic [63:0] sa, sb;
            int          ea, eb;
            s = a[31] ^ b[31];
            if (is_nan(a)) return a | QUIET;
            if (is_nan(b)) return b | QUIET;
            a_inf  = a[30:0] == 31'h7F80_0000;
            b_inf  = b[30:0] == 31'h7F80_0000;
            a_zero = a[30:0] == 31'd0;
            b_zero = b[30:0] == 31'd0;
            if ((a_inf && b_zero) || (b_inf && a_zero)) return 32'hFFC0_0000;
            if (a_inf || b_inf) return {s, 31'h7F80_0000};
            if (a_zero || b_zero) return {s, 31'd0};
            split(a, sa, ea);
            split(b, sb, eb);
            return round_f32(s, sa * sb, ea + eb, 1'b0);
        endfunction

        // both operands non-negative
        function logic [31:0] add_f32(logic [31:0] a, logic [31:0] b);
            logic [63:0] sa, sb, t;
            logic [31:0] big;
            int          ea, eb, te;
            if (is_nan(a)) return a | QUIET;
            if (is_nan(b)) return b | QUIET;
            if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return 32'h7F80_0000;
            if (b[30:0] == 31'd0) return a;
            if (a[30:0] == 31'd0) return b;
            split(a, sa, ea);
            split(b, sb, eb);
            big = a;
            if (ea < eb) begin
                t = sa; sa = sb; sb = t;
                te = ea; ea = eb; eb = te;
                big = b;
            end
            // far smaller addend is below half an ulp
            if (ea - eb > 30) return big;
            return round_f32(1'b0, (sa << (ea - eb)) + sb, eb, 1'b0);
        endfunction

        // dividend non-negative, divisor positive
        function logic [31:0] div_f32(logic [31:0] a, logic [31:0] b);
            logic [63:0] sa, sb;
            int          ea, eb;
            if (is_nan(a)) return a | QUIET;
            if (is_nan(b)) return b | QUIET;
            if (b[30:0] == 31'h7F80_0000)
                return (a[30:0] == 31'h7F80_0000) ? 32'hFFC0_0000 : 32'd0;
            if (a[30:0] == 31'h7F80_0000) return 32'h7F80_0000;
            if (a[30:0] == 31'd0) return 32'd0;
            split(a, sa, ea);
            split(b, sb, eb);
            while (!sa[63]) begin
                sa = sa << 1;
                ea--;
            end
            return round_f32(1'b0, sa / sb, ea - eb, (sa % sb) != 64'd0);
        endfunction

        function logic [31:0] sqrt_f32(logic [31:0] a);
            logic [63:0] sa, rem, root, bitv;
            int          ea, p, lsh, e2;
            if (a[30:23] == 8'hFF || a[30:0] == 31'd0) return a;
            split(a, sa, ea);
            p = 0;
            for (int i = 0; i < 64; i++) begin
                if (sa[i]) p = i;
            end
            lsh = 62 - p;
            if (((ea - lsh) & 1) != 0) lsh--;
            sa = sa << lsh;
            e2 = ea - lsh;
            rem = sa;
            root = 64'd0;
            bitv = 64'd1 << 62;
            while (bitv > sa) bitv = bitv >> 2;
            while (bitv != 64'd0) begin
                if (rem >= root + bitv) begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return round_f32(1'b0, root, e2 / 2, rem != 64'd0);
        endfunction

        function logic [15:0] to_bf16(logic [31:0] f);
            logic [31:0] r;
            if (is_nan(f)) return f[31:16] | 16'h0040;
            r = f + 32'h0000_7FFF + {31'd0, f[16]};
            return r[31:16];
        endfunction

        function void set_length(int v);
            length_reg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_element(logic [15:0] x);
            int           len, n;
            logic [31:0]  mean, scale;
            norm_result_t r;
            len = length_reg;
            if (len < 1) len = 1;
            if (len > 64) len = 64;
            if (filled >= 64) filled = 63;
            row_buf[filled] = x;
            sq_sum = add_f32(sq_sum, mul_f32({x, 16'd0}, {x, 16'd0}));
            if (filled + 1 < len) begin
                filled++;
                return;
            end
            n = filled + 1;
            mean = add_f32(div_f32(sq_sum, round_f32(1'b0, 64'(n), 0, 1'b0)), EPS_F32);
            scale = {to_bf16(div_f32(ONE_F32, sqrt_f32(mean))), 16'd0};
            for (int i = 0; i < n; i++) begin
                r.value = to_bf16(mul_f32({row_buf[i], 16'd0}, scale));
                r.last  = (i + 1 == n);
                expected_q.push_back(r);
            end
            sq_sum = 32'd0;
            filled = 0;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        task check_result(logic [15:0] v, logic last);
            norm_result_t e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h last %b", v, last));
                return;
            end
            e = expected_q.pop_front();
            if (v !== e.value)
                report_mismatch($sformatf("value %h, expected %h", v, e.value));
            if (last !== e.last)
                report_mismatch($sformatf("last %b, expected %b", last, e.last));
        endtask
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [15:0]      s_element_value = 16'd0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [15:0]      m_normalized_value;
    logic             m_last_of_row;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [rmsn_pkg::CFG_W-1:0] cfg_row_length = '0;

    row_norm_scoreboard sb = new();
    int  sent_count = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    // no-gap stretches on both sides
    bit  calm = 1'b0;

    always #1 aclk = ~aclk;

    rms_norm_row u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_element_value    (s_element_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_normalized_value (m_normalized_value),
        .m_last_of_row      (m_last_of_row),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_row_length     (cfg_row_length)
    );

    // result side: check each transfer, draw a stall before the next one
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_normalized_value, m_last_of_row);
                stall_left = calm ? 0 : $urandom_range(0, 14);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
            // watchdog: cycles with no transfer on any channel
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("rms_norm_row_test: FAIL");
                $finish;
            end
        end
    end

    // every task below but end_burst returns right after a rising edge
    task send_element(logic [15:0] x);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_element_value <= x;
        do @(posedge aclk); while (!s_ready);
        sb.note_element(x);
        sent_count++;
    endtask

    task end_burst();
        s_valid <= 1'b0;
    endtask

    // wait for every expected transfer, then let the scale pipe drain
    task wait_drained();
        end_burst();
        while (sb.pending() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task write_length(int v);
        cfg_valid <= 1'b1;
        cfg_row_length <= rmsn_pkg::CFG_W'(v);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_length(v);
    endtask

    function logic [15:0] rand_element();
        // mostly moderate magnitudes, some raw patterns for nan, inf and subnormals
        if ($urandom_range(0, 99) < 85)
            return {1'($urandom), 8'($urandom_range(110, 140)), 7'($urandom)};
        return 16'($urandom);
    endfunction

    logic [15:0] specials[12] = '{16'h0000, 16'h8000, 16'h3F80, 16'hBF80, 16'h7F80,
                                  16'hFF80, 16'h7FC1, 16'hFF81, 16'h0001, 16'h807F,
                                  16'h7F7F, 16'h0080};

    initial begin
        int len, rows;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full row at the reset length
        for (int i = 0; i < 64; i++) send_element(rand_element());
        wait_drained();

        // single-element rows over the special values
        write_length(1);
        foreach (specials[i]) send_element(specials[i]);
        wait_drained();

        // inf square sum gives a zero scale, inf times zero is nan
        write_length(2);
        send_element(16'h7F80);
        send_element(16'h0000);
        wait_drained();

        // zero length acts as one
        write_length(0);
        send_element(16'h4040);
        send_element(16'hC0A0);
        wait_drained();

        // oversize length, then lowered mid-row so the next element closes it
        write_length(127);
        for (int i = 0; i < 5; i++) send_element(rand_element());
        wait_drained();
        write_length(3);
        send_element(rand_element());
        wait_drained();

        while (sent_count < TARGET_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
            rows = $urandom_range(1, 3);
            write_length(len);
            for (int i = 0; i < len * rows; i++) send_element(rand_element());
            wait_drained();
        end
        calm = 1'b0;

        if (sb.mismatches == 0) begin
            $display("rms_norm_row_test: PASS");
        end else begin
            $display("rms_norm_row_test: FAIL");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/rmsn_pkg.sv
rtl/rmsn_row_buf.sv
rtl/rmsn_scale.sv
rtl/rms_norm_row.sv
sim/rms_norm_row_test.sv
